@@ rtl/dubs_pkg.sv @@
// Package for the dispense, UV and backwash sequencer: item types and code constants.
package dubs_pkg;

    // Item kinds
    localparam logic [1:0] KIND_TICK       = 2'd0;
    localparam logic [1:0] KIND_BW_REQUEST = 2'd1;
    localparam logic [1:0] KIND_ABORT      = 2'd2;
    localparam logic [1:0] KIND_TAKE_FAULT = 2'd3;

    // Sequencer phases
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_UV_PRE  = 2'd1;
    localparam logic [1:0] PH_DISP    = 2'd2;
    localparam logic [1:0] PH_UV_POST = 2'd3;

    // Dispense modes
    localparam logic [1:0] MODE_TIME  = 2'd0;
    localparam logic [1:0] MODE_PULSE = 2'd1;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_BW_DEFAULT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISP_TIME  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_GOAL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DISP_MODE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERRIDE   = 3'd4;

    // Timing constants and the dispense count limit
    localparam logic [31:0] BW_RESET_MS = 32'd5000;
    localparam logic [31:0] UV_PRE_MS   = 32'd100;
    localparam logic [31:0] UV_TAIL_MS  = 32'd100;
    localparam logic [2:0]  TALLY_MAX   = 3'd5;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] now_ms;
        logic        dispense_cmd;
        logic [1:0]  water_level;
        logic        uv_good;
        logic [31:0] flow_count;
        logic [31:0] bw_len_ms;
    } t_in_item;

    typedef struct packed {
        logic        backwash_on;
        logic        dispense_on;
        logic        uv_on;
        logic [1:0]  phase;
        logic [2:0]  dispenses_done;
        logic        uv_fault;
        logic [31:0] backwash_left_ms;
    } t_out_item;

endpackage

@@ rtl/dubs_in_stage.sv @@
// Input register stage: holds one accepted item for the sequencer core.
module dubs_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  dubs_pkg::t_in_item i_data,
    input  logic               i_advance,
    output logic               o_stall,
    output logic               o_valid,
    output dubs_pkg::t_in_item o_data
);

    logic               r_valid;
    dubs_pkg::t_in_item r_data;
    logic               take;

    // The register can load when it is empty or its item moves on this cycle.
    assign take = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_valid) begin
            r_data <= i_data;
        end
    end

    assign o_stall = !take;
    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ rtl/dubs_core.sv @@
// Sequencer core: configuration registers, state and the per-item decision logic.
module dubs_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_fire,
    input  dubs_pkg::t_in_item               i_item,
    input  logic                             i_cfg_we,
    input  logic [dubs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]                      i_cfg_data,
    output dubs_pkg::t_out_item              o_result
);

    // Configuration
    logic [31:0] r_bw_default_ms;
    logic [31:0] r_disp_time_ms;
    logic [15:0] r_pulse_goal;
    logic [1:0]  r_disp_mode;
    logic        r_override_on;

    // State
    logic [1:0]  r_phase,         n_phase;
    logic [31:0] r_phase_start,   n_phase_start;
    logic        r_prev_cmd,      n_prev_cmd;
    logic [2:0]  r_tally,         n_tally;
    logic        r_bw_request,    n_bw_request;
    logic [31:0] r_bw_request_ms, n_bw_request_ms;
    logic        r_bw_active,     n_bw_active;
    logic [31:0] r_bw_start,      n_bw_start;
    logic [31:0] r_bw_run,        n_bw_run;
    logic [31:0] r_pulse_base,    n_pulse_base;
    logic        r_fault,         n_fault;

    logic        want_disp;
    logic        want_uv;
    logic        fault_out;
    logic [31:0] bw_left;

    logic [31:0] bw_el;
    logic        bw_expired;
    logic [31:0] bw_req_run;
    logic        lvl_ok;
    logic        bw_start;
    logic [31:0] ph_el;
    logic [31:0] pulse_el;
    logic        profile_ok;
    logic        cmd_edge;
    logic        disp_done;
    logic [2:0]  tally_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bw_default_ms <= dubs_pkg::BW_RESET_MS;
            r_disp_time_ms  <= '0;
            r_pulse_goal    <= '0;
            r_disp_mode     <= dubs_pkg::MODE_TIME;
            r_override_on   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dubs_pkg::CFG_BW_DEFAULT: r_bw_default_ms <= i_cfg_data;
                dubs_pkg::CFG_DISP_TIME:  r_disp_time_ms  <= i_cfg_data;
                dubs_pkg::CFG_PULSE_GOAL: r_pulse_goal    <= i_cfg_data[15:0];
                dubs_pkg::CFG_DISP_MODE:  r_disp_mode     <= i_cfg_data[1:0];
                dubs_pkg::CFG_OVERRIDE:   r_override_on   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Shared timing terms
    assign bw_el      = i_item.now_ms - r_bw_start;
    assign bw_expired = bw_el >= r_bw_run;
    assign bw_req_run = (r_bw_request_ms != '0) ? r_bw_request_ms : r_bw_default_ms;
    assign lvl_ok     = (i_item.water_level > 2'd1) ||
                        (r_override_on && (i_item.water_level != 2'd0));
    assign bw_start   = r_bw_request && !r_bw_active && lvl_ok && (bw_req_run != '0);
    assign ph_el      = i_item.now_ms - r_phase_start;
    assign pulse_el   = i_item.flow_count - r_pulse_base;
    assign cmd_edge   = i_item.dispense_cmd && !r_prev_cmd;

    always_comb begin
        case (r_disp_mode)
            dubs_pkg::MODE_TIME:  profile_ok = r_disp_time_ms != '0;
            dubs_pkg::MODE_PULSE: profile_ok = r_pulse_goal != '0;
            default:              profile_ok = 1'b0;
        endcase
    end

    always_comb begin
        case (r_disp_mode)
            dubs_pkg::MODE_TIME:  disp_done = (r_disp_time_ms == '0) ||
                                              (ph_el >= r_disp_time_ms);
            dubs_pkg::MODE_PULSE: disp_done = (r_pulse_goal == '0) ||
                                              (pulse_el >= {16'd0, r_pulse_goal});
            default:              disp_done = 1'b1;
        endcase
    end

    assign tally_base = bw_start ? 3'd0 : r_tally;

    always_comb begin
        n_phase         = r_phase;
        n_phase_start   = r_phase_start;
        n_prev_cmd      = r_prev_cmd;
        n_tally         = r_tally;
        n_bw_request    = r_bw_request;
        n_bw_request_ms = r_bw_request_ms;
        n_bw_active     = r_bw_active;
        n_bw_start      = r_bw_start;
        n_bw_run        = r_bw_run;
        n_pulse_base    = r_pulse_base;
        n_fault         = r_fault;
        want_disp       = 1'b0;
        want_uv         = 1'b0;
        fault_out       = r_fault;
        bw_left         = '0;

        if (i_item.kind == dubs_pkg::KIND_TICK) begin
            // Backwash overlay first: a pending request starts or stops it,
            // then a running backwash ends on time or an empty tank.
            n_bw_request = 1'b0;
            if (r_bw_request) begin
                n_bw_request_ms = '0;
            end
            if (bw_start) begin
                n_bw_active = 1'b1;
                n_bw_start  = i_item.now_ms;
                n_bw_run    = bw_req_run;
                bw_left     = bw_req_run;
            end else begin
                n_bw_active = r_bw_active && !r_bw_request && !bw_expired &&
                              (i_item.water_level != 2'd0);
                bw_left     = n_bw_active ? (r_bw_run - bw_el) : '0;
            end

            n_tally    = tally_base;
            n_prev_cmd = i_item.dispense_cmd;
            unique case (r_phase)
                dubs_pkg::PH_IDLE: begin
                    if (cmd_edge && (i_item.water_level != 2'd0) && profile_ok) begin
                        want_uv       = 1'b1;
                        n_phase       = dubs_pkg::PH_UV_PRE;
                        n_phase_start = i_item.now_ms;
                    end
                end
                dubs_pkg::PH_UV_PRE: begin
                    want_uv = 1'b1;
                    if (ph_el >= dubs_pkg::UV_PRE_MS) begin
                        n_phase_start = i_item.now_ms;
                        if (i_item.uv_good) begin
                            want_disp    = 1'b1;
                            n_pulse_base = i_item.flow_count;
                            n_phase      = dubs_pkg::PH_DISP;
                        end else begin
                            n_fault = 1'b1;
                            n_phase = dubs_pkg::PH_IDLE;
                        end
                    end
                end
                dubs_pkg::PH_DISP: begin
                    want_uv = 1'b1;
                    if (!i_item.uv_good) begin
                        n_fault       = 1'b1;
                        n_phase       = dubs_pkg::PH_IDLE;
                        n_phase_start = i_item.now_ms;
                    end else if (disp_done) begin
                        if (tally_base < dubs_pkg::TALLY_MAX) begin
                            n_tally = tally_base + 3'd1;
                        end
                        n_phase       = dubs_pkg::PH_UV_POST;
                        n_phase_start = i_item.now_ms;
                    end else begin
                        want_disp = 1'b1;
                    end
                end
                dubs_pkg::PH_UV_POST: begin
                    want_uv = 1'b1;
                    if (ph_el >= dubs_pkg::UV_TAIL_MS) begin
                        want_uv       = 1'b0;
                        n_phase       = dubs_pkg::PH_IDLE;
                        n_phase_start = i_item.now_ms;
                    end
                end
                default: ;
            endcase
            fault_out = n_fault;
        end else begin
            if (i_item.kind == dubs_pkg::KIND_BW_REQUEST) begin
                n_bw_request    = 1'b1;
                n_bw_request_ms = i_item.bw_len_ms;
            end
            if (i_item.kind == dubs_pkg::KIND_ABORT) begin
                if (r_phase != dubs_pkg::PH_IDLE) begin
                    n_phase       = dubs_pkg::PH_IDLE;
                    n_phase_start = i_item.now_ms;
                end
                n_prev_cmd = 1'b0;
            end
            if (i_item.kind == dubs_pkg::KIND_TAKE_FAULT) begin
                n_fault = 1'b0;
            end
            want_uv   = n_phase != dubs_pkg::PH_IDLE;
            want_disp = n_phase == dubs_pkg::PH_DISP;
            bw_left   = (r_bw_active && !bw_expired) ? (r_bw_run - bw_el) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= dubs_pkg::PH_IDLE;
            r_phase_start   <= '0;
            r_prev_cmd      <= 1'b0;
            r_tally         <= '0;
            r_bw_request    <= 1'b0;
            r_bw_request_ms <= '0;
            r_bw_active     <= 1'b0;
            r_bw_start      <= '0;
            r_bw_run        <= dubs_pkg::BW_RESET_MS;
            r_pulse_base    <= '0;
            r_fault         <= 1'b0;
        end else if (i_fire) begin
            r_phase         <= n_phase;
            r_phase_start   <= n_phase_start;
            r_prev_cmd      <= n_prev_cmd;
            r_tally         <= n_tally;
            r_bw_request    <= n_bw_request;
            r_bw_request_ms <= n_bw_request_ms;
            r_bw_active     <= n_bw_active;
            r_bw_start      <= n_bw_start;
            r_bw_run        <= n_bw_run;
            r_pulse_base    <= n_pulse_base;
            r_fault         <= n_fault;
        end
    end

    always_comb begin
        o_result.backwash_on      = n_bw_active;
        o_result.dispense_on      = want_disp;
        o_result.uv_on            = want_uv;
        o_result.phase            = n_phase;
        o_result.dispenses_done   = n_tally;
        o_result.uv_fault         = fault_out;
        o_result.backwash_left_ms = bw_left;
    end

endmodule

@@ rtl/dubs_out_stage.sv @@
// Result register stage: holds one finished result item until the receiver takes it.
module dubs_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  dubs_pkg::t_out_item i_data,
    input  logic                i_stall,
    output logic                o_advance,
    output logic                o_valid,
    output dubs_pkg::t_out_item o_data
);

    logic                r_valid;
    dubs_pkg::t_out_item r_data;

    // The register frees up when it is empty or its item is taken this cycle.
    assign o_advance = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_valid) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ rtl/dispense_uv_backwash_sequencer.sv @@
// Top level of the water dispense sequencer with UV supervision and backwash overlay.
//
// Input channel: i_in_valid, o_in_stall and i_in_data. An item is taken at a
// rising edge where i_in_valid is high and o_in_stall is low. Each item is a
// tick update, a backwash request, an abort or a take-fault request, and each
// gives exactly one result item on the output channel.
// Output channel: o_out_valid, i_out_stall and o_out_data. A result item is
// taken at an edge where o_out_valid is high and i_out_stall is low.
// Configuration: i_cfg_valid, o_cfg_ready, i_cfg_index and i_cfg_data. The
// port is always ready; indexes past the last register are ignored. Writes
// are meant to happen only while no item is in flight.
// An item lands in the input register; when the result register can take
// it, the sequencer state updates and the result register loads together.
// One item per cycle is sustained while the receiver does not stall, since
// the whole decision is a single pass of subtractions and compares between them.
// When the receiver stalls, the result register holds its item and the input
// register keeps one more; only then is o_in_stall raised.
// Reset (synchronous, active low) empties both registers, returns the
// sequencer to idle and loads the register defaults, backwash default 5000 ms.
module dispense_uv_backwash_sequencer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  dubs_pkg::t_in_item             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output dubs_pkg::t_out_item            o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [dubs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);

    logic                advance;
    logic                in_valid;
    dubs_pkg::t_in_item  in_item;
    logic                fire;
    dubs_pkg::t_out_item result;

    assign o_cfg_ready = 1'b1;

    dubs_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_data    (i_in_data),
        .i_advance (advance),
        .o_stall   (o_in_stall),
        .o_valid   (in_valid),
        .o_data    (in_item)
    );

    // The held item is worked on in the cycle that the result register can take it.
    assign fire = in_valid && advance;

    dubs_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (in_item),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_result    (result)
    );

    dubs_out_stage u_out_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (in_valid),
        .i_data    (result),
        .i_stall   (i_out_stall),
        .o_advance (advance),
        .o_valid   (o_out_valid),
        .o_data    (o_out_data)
    );

endmodule

@@ rtl/dubs_checker.sv @@
// Port-level checker for the sequencer, bound to the top level.
module dubs_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input dubs_pkg::t_out_item o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result item changed while stalled");

    a_disp_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.dispense_on |->
            o_out_data.phase == dubs_pkg::PH_DISP && o_out_data.uv_on)
        else $error("valve open outside the dispensing phase");

    a_bw_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.backwash_on |-> o_out_data.backwash_left_ms == '0)
        else $error("backwash time left while backwash is off");

    a_tally: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.dispenses_done <= dubs_pkg::TALLY_MAX)
        else $error("dispense count past its limit");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

endmodule

bind dispense_uv_backwash_sequencer dubs_checker u_dubs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
